// ----- rtl/core/brs_pkg.sv -----
// Shared types and constants of the bus request retry scheduler.
`timescale 1ns / 1ps
`default_nettype none

package brs_pkg;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  typedef enum logic [1:0] {
    CFG_ENABLE      = 2'd0,
    CFG_TIMEOUT     = 2'd1,
    CFG_MAX_RETRIES = 2'd2
  } cfg_idx_t;

  localparam logic [15:0] TimeoutReset    = 16'd100;
  localparam logic [7:0]  MaxRetriesReset = 8'd3;
  localparam logic [7:0]  DeselectAll     = 8'hFF;
  localparam logic [8:0]  RetrySat        = 9'd511;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_REPLY   = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_POLL  = 2'd2,
    KIND_UNDEF = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RESP_READ  = 2'd0,
    RESP_WRITE = 2'd1,
    RESP_POLL  = 2'd2,
    RESP_OTHER = 2'd3
  } resp_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_ISSUE     = 3'd1,
    EV_READ_DONE = 3'd2,
    EV_FAILED    = 3'd3,
    EV_NO_RESP   = 3'd4,
    EV_POLL_DONE = 3'd5,
    EV_DROPPED   = 3'd6
  } event_t;

  // One queued request, 50 bits.
  typedef struct packed {
    logic [7:0]  slot;
    logic [1:0]  kind;
    logic [7:0]  obj_id;
    logic [15:0] buffer_ref;
    logic [15:0] length;
  } req_t;

  localparam int ReqW = $bits(req_t);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  req_kind;
    logic [7:0]  slot;
    logic [7:0]  obj_id;
    logic [15:0] buffer_ref;
    logic [15:0] data_length;
    logic [1:0]  resp_type;
    logic        resp_ok;
    logic [15:0] unparsed_size;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  out_slot;
    logic [1:0]  out_kind;
    logic [7:0]  out_obj_id;
    logic [15:0] out_buffer_ref;
    logic [15:0] out_length;
    logic [15:0] out_unparsed;
    logic        select_valid;
    logic [7:0]  select_slot;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } queue_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/brs_chan.sv -----
// Valid/ready channel carrying one payload of a given type.
`timescale 1ns / 1ps
`default_nettype none

interface brs_chan #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/brs_ram.sv -----
// Simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module brs_ram #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/brs_queue.sv -----
// Pending request FIFO: pointers, fill count and head read-ahead over a RAM.
`timescale 1ns / 1ps
`default_nettype none

module brs_queue #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire brs_pkg::queue_ctrl_t ctrl,
  input  wire brs_pkg::req_t        wdata,
  output brs_pkg::queue_stat_t      stat,
  output brs_pkg::req_t             head_data
);
  import brs_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(QUEUE_DEPTH - 1);

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic          byp_hit;
  req_t          byp_data;
  logic [ReqW-1:0] rd_data;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    if (ctrl.clear) begin
      head_next  = '0;
      tail_next  = '0;
      count_next = '0;
    end else begin
      if (ctrl.push) begin
        tail_next  = (tail == LastIdx) ? '0 : tail + 1'b1;
        count_next = count + 1'b1;
      end
      if (ctrl.pop) begin
        head_next  = (head == LastIdx) ? '0 : head + 1'b1;
        count_next = count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      count   <= '0;
      byp_hit <= 1'b0;
    end else begin
      head    <= head_next;
      tail    <= tail_next;
      count   <= count_next;
      // forward a write that lands on the address being read this cycle
      byp_hit <= ctrl.push && (tail == head_next);
    end
    byp_data <= wdata;
  end

  // read ahead at the next head so the entry is ready when the next item pops
  brs_ram #(
    .WIDTH (ReqW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctrl.push),
    .waddr (tail),
    .wdata (wdata),
    .raddr (head_next),
    .rdata (rd_data)
  );

  assign head_data  = byp_hit ? byp_data : req_t'(rd_data);
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(QUEUE_DEPTH));

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue fill count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head == tail))
    else $error("empty queue with unequal pointers");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |-> !stat.full && !ctrl.pop)
    else $error("push into a full queue or together with a pop");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/bus_request_retry_scheduler.sv -----
// Top level: input register, scheduler control, result register and config.
//
// Usage: commands (enqueue, tick, reply, clear queue) arrive on the request
// channel; each one yields exactly one transaction on the result channel,
// carrying the event code, the request concerned and the slot select.
// Configuration (enable, timeout_ticks, max_retries) is written through
// cfg_we / cfg_index / cfg_data, one register per cycle, while idle.
// A command accepted on the request channel is held in the input register
// until the result register is free, and its result is then loaded there.
// Throughput: one command per cycle while the receiver takes each result.
// The pending queue is a RAM whose head is read ahead at the next head
// address, with write forwarding, so a tick can issue a request queued
// by the command just before it.
// Reset (rst, synchronous) empties the queue, drops any request in flight
// and loads the register defaults: disabled, 100 ticks, 3 retries.
// When the receiver stalls, the result is held, the input register keeps
// one more command, and then request.ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module bus_request_retry_scheduler #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [brs_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [brs_pkg::CfgDataW-1:0]  cfg_data,
  brs_chan.sink                              request,
  brs_chan.source                            result
);
  import brs_pkg::*;

  // configuration
  logic        enable;
  logic [15:0] timeout_ticks;
  logic [7:0]  max_retries;

  // input and result registers
  logic      in_full;
  in_item_t  item;
  logic      res_valid;
  out_item_t res;
  out_item_t res_next;
  logic      fire;

  // scheduler state
  req_t        current_request, current_next;
  logic        awaiting_reply, awaiting_next;
  logic [15:0] elapsed_ticks, elapsed_next;
  logic [8:0]  retry_count, retry_next;

  queue_ctrl_t q_ctrl;
  queue_stat_t q_stat;
  req_t        q_wdata;
  req_t        q_head;

  function automatic out_item_t put_req(input event_t ev, input req_t r);
    out_item_t o;
    o                = '0;
    o.event_res      = ev;
    o.out_slot       = r.slot;
    o.out_kind       = r.kind;
    o.out_obj_id     = r.obj_id;
    o.out_buffer_ref = r.buffer_ref;
    o.out_length     = r.length;
    return o;
  endfunction

  assign fire          = in_full && (!res_valid || result.ready);
  assign request.ready = !in_full || fire;
  assign result.valid  = res_valid;
  assign result.payload = res;

  // build the request an enqueue would store
  always_comb begin
    q_wdata.slot = item.slot;
    if (item.req_kind == KIND_READ || item.req_kind == KIND_WRITE) begin
      q_wdata.kind       = item.req_kind;
      q_wdata.obj_id     = item.obj_id;
      q_wdata.buffer_ref = item.buffer_ref;
      q_wdata.length     = item.data_length;
    end else begin
      q_wdata.kind       = KIND_POLL;
      q_wdata.obj_id     = '0;
      q_wdata.buffer_ref = '0;
      q_wdata.length     = '0;
    end
  end

  always_comb begin
    logic [8:0] retry_inc;
    res_next      = '0;
    q_ctrl        = '0;
    current_next  = current_request;
    awaiting_next = awaiting_reply;
    elapsed_next  = elapsed_ticks;
    retry_next    = retry_count;
    retry_inc     = (retry_count == RetrySat) ? retry_count : retry_count + 1'b1;
    case (item.cmd)
      CMD_ENQUEUE: begin
        if (q_stat.full) begin
          res_next = put_req(EV_DROPPED, q_wdata);
        end else begin
          q_ctrl.push = fire;
        end
      end
      CMD_TICK: begin
        if (enable) begin
          if (awaiting_reply) begin
            if (elapsed_ticks >= timeout_ticks) begin
              retry_next = retry_inc;
              if (retry_inc > {1'b0, max_retries}) begin
                awaiting_next = 1'b0;
                res_next      = put_req(EV_NO_RESP, current_request);
              end else begin
                // re-issue the same request
                res_next              = put_req(EV_ISSUE, current_request);
                res_next.select_valid = 1'b1;
                res_next.select_slot  = current_request.slot;
                elapsed_next          = '0;
              end
            end else begin
              elapsed_next = elapsed_ticks + 1'b1;
            end
          end else if (!q_stat.empty) begin
            q_ctrl.pop            = fire;
            current_next          = q_head;
            retry_next            = '0;
            elapsed_next          = '0;
            awaiting_next         = 1'b1;
            res_next              = put_req(EV_ISSUE, q_head);
            res_next.select_valid = 1'b1;
            res_next.select_slot  = q_head.slot;
          end
        end
      end
      CMD_REPLY: begin
        if (awaiting_reply) begin
          case (item.resp_type)
            RESP_READ: begin
              if (current_request.kind == KIND_READ) begin
                awaiting_next = 1'b0;
                if (item.resp_ok) begin
                  res_next              = put_req(EV_READ_DONE, current_request);
                  res_next.out_unparsed = item.unparsed_size;
                end else begin
                  res_next = put_req(EV_FAILED, current_request);
                end
              end
            end
            RESP_WRITE: begin
              if (current_request.kind == KIND_WRITE) begin
                awaiting_next = 1'b0;
                res_next      = put_req(item.resp_ok ? EV_NONE : EV_FAILED,
                                        current_request);
              end
            end
            RESP_POLL: begin
              if (current_request.kind == KIND_POLL) begin
                awaiting_next = 1'b0;
                res_next      = put_req(EV_POLL_DONE, current_request);
              end
            end
            default: begin
              awaiting_next = 1'b0;
              res_next      = put_req(EV_NONE, current_request);
            end
          endcase
          // every finished wait drives the deselect
          if (!awaiting_next) begin
            res_next.select_valid = 1'b1;
            res_next.select_slot  = DeselectAll;
          end
        end
      end
      default: begin
        q_ctrl.clear = fire;
      end
    endcase
  end

  brs_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (q_ctrl),
    .wdata     (q_wdata),
    .stat      (q_stat),
    .head_data (q_head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      timeout_ticks  <= TimeoutReset;
      max_retries    <= MaxRetriesReset;
      in_full        <= 1'b0;
      res_valid      <= 1'b0;
      awaiting_reply <= 1'b0;
      elapsed_ticks  <= '0;
      retry_count    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE:      enable        <= cfg_data[0];
          CFG_TIMEOUT:     timeout_ticks <= cfg_data;
          CFG_MAX_RETRIES: max_retries   <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (request.valid && request.ready) begin
        in_full <= 1'b1;
      end else if (fire) begin
        in_full <= 1'b0;
      end
      if (fire) begin
        res_valid      <= 1'b1;
        awaiting_reply <= awaiting_next;
        elapsed_ticks  <= elapsed_next;
        retry_count    <= retry_next;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
    if (request.valid && request.ready) begin
      item <= request.payload;
    end
    if (fire) begin
      res             <= res_next;
      current_request <= current_next;
    end
  end

`ifndef SYNTHESIS
  a_issue_waits: assert property (@(posedge clk) disable iff (rst)
    fire && (res_next.event_res == EV_ISSUE) |=> awaiting_reply)
    else $error("request issued without waiting for a reply");

  a_idle_reply_quiet: assert property (@(posedge clk) disable iff (rst)
    fire && !awaiting_reply && (item.cmd == CMD_REPLY) |-> (res_next == '0))
    else $error("reply while idle produced a result");

  a_drop_only_full: assert property (@(posedge clk) disable iff (rst)
    fire && (res_next.event_res == EV_DROPPED) |-> q_stat.full && !q_ctrl.push)
    else $error("enqueue dropped while queue had room");
`endif

endmodule

`default_nettype wire
